[src/ccp_pkg.sv]
// shared constants, types and helpers for the capsule contact point unit
`default_nettype none
package ccp_pkg;

  localparam int COORD_BITS = 21;
  localparam int NORM_BITS  = 16;
  localparam int NORM_FRAC  = 14;
  localparam int RAD_BITS   = 20;
  localparam int SEG_FRAC   = 30;
  localparam int KIND_W     = 2;

  localparam int VEC_BITS   = 3 * COORD_BITS;
  localparam int NVEC_BITS  = 3 * NORM_BITS;
  localparam int IN_RAW_W   = 4 * VEC_BITS + RAD_BITS + NVEC_BITS;
  localparam int IN_DATA_W  = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 3 * COORD_BITS;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // datapath widths
  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int DOT_W   = 2 * DIFF_W + 2;
  localparam int PROD_W  = 2 * DOT_W;
  localparam int DIV_W   = PROD_W;
  localparam int Q_W     = SEG_FRAC + 1;
  localparam int DIV_LAT = SEG_FRAC + 1;
  localparam int NRP_W   = NORM_BITS + RAD_BITS + 1;
  localparam int NR_W    = NRP_W - NORM_FRAC;
  localparam int TN_W    = DOT_W + Q_W + 2;
  localparam int DPS_W   = DIFF_W + Q_W + 1;
  localparam int RND_W   = DPS_W - SEG_FRAC;
  localparam int BASE_W  = RND_W + 1;
  localparam int SUM_W   = BASE_W + 1;

  // split multipliers: dot products are cut into a signed high and unsigned low half
  localparam int HALF_W  = DOT_W / 2;
  localparam int PP_W    = 2 * (HALF_W + 1);
  localparam int TP_W    = HALF_W + Q_W + 2;

  // body pair kinds
  localparam logic [KIND_W-1:0] KIND_SPHERE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CAP_SPH = 2'd1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [DOT_W-1:0]      dot_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [NR_W-1:0]       nr_t;
  typedef logic signed [HALF_W:0]       half_t;
  typedef logic signed [PP_W-1:0]       pp_t;

  // one signed component of a packed coordinate vector
  function automatic coord_t vec_comp(input logic [VEC_BITS-1:0] v, input int k);
    return coord_t'(v[k*COORD_BITS +: COORD_BITS]);
  endfunction

  // one signed component of a packed normal vector
  function automatic logic signed [NORM_BITS-1:0] nvec_comp(
      input logic [NVEC_BITS-1:0] v, input int k);
    return v[k*NORM_BITS +: NORM_BITS];
  endfunction

endpackage
`default_nettype wire

[src/ccp_div.sv]
// pipelined clamped divider, one quotient bit per stage, result in [0, 1]
`default_nettype none
module ccp_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [ccp_pkg::DIV_W-1:0]  num,
  input  wire logic signed [ccp_pkg::DIV_W-1:0]  den,
  output logic             [ccp_pkg::Q_W-1:0]    quot
);
  import ccp_pkg::*;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dv;
    logic [Q_W-1:0]   q;
  } dstage_t;

  dstage_t st_r   [DIV_LAT];
  dstage_t st_nxt [DIV_LAT];

  always_comb begin
    logic [DIV_W-1:0] rem2;
    // entry: clamp cases finish at once, others start the long division
    st_nxt[0].dv   = den;
    st_nxt[0].rem  = num;
    st_nxt[0].q    = '0;
    st_nxt[0].done = 1'b1;
    if (num <= 0) begin
      st_nxt[0].q = '0;
    end else if (num >= den) begin
      st_nxt[0].q = Q_W'(1) << SEG_FRAC;
    end else begin
      st_nxt[0].done = 1'b0;
    end
    // restoring steps
    for (int k = 1; k < DIV_LAT; k++) begin
      st_nxt[k] = st_r[k-1];
      rem2 = {st_r[k-1].rem[DIV_W-2:0], 1'b0};
      if (!st_r[k-1].done) begin
        if (rem2 >= st_r[k-1].dv) begin
          st_nxt[k].rem = rem2 - st_r[k-1].dv;
          st_nxt[k].q   = {st_r[k-1].q[Q_W-2:0], 1'b1};
        end else begin
          st_nxt[k].rem = rem2;
          st_nxt[k].q   = {st_r[k-1].q[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_LAT; k++) st_r[k] <= st_nxt[k];
    end
  end

  assign quot = st_r[DIV_LAT-1].q;

endmodule
`default_nettype wire

[src/capsule_contact_point_unit.sv]
// Capsule contact point unit. Throughput one item per cycle while the output
// register is not stalled; the 31-stage divider pipeline sets most of the
// depth. The whole pipeline advances whenever the output register is empty or
// taken.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// not reset.
`default_nettype none
module capsule_contact_point_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // a_point_a, a_point_b, a_radius, b_point_a, b_point_b, contact_normal
  input  wire logic [ccp_pkg::IN_DATA_W-1:0]     in_tdata,
  // kind
  input  wire logic [ccp_pkg::KIND_W-1:0]        in_tuser,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // point_x, point_y, point_z, zero pad
  output logic [ccp_pkg::OUT_DATA_W-1:0]         out_tdata
);
  import ccp_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic                    azero;
    logic                    zs;
    logic                    corr;
    logic [DOT_W-1:0]        bb;
    logic [DOT_W-1:0]        ff;
    logic [DOT_W-1:0]        ee;
    logic [3*COORD_BITS-1:0] apa;
    logic [3*DIFF_W-1:0]     d1;
    logic [3*NR_W-1:0]       nr;
  } side_t;

  function automatic dot_t dot3(input diff_t a0, a1, a2, b0, b1, b2);
    return DOT_W'(a0 * b0) + DOT_W'(a1 * b1) + DOT_W'(a2 * b2);
  endfunction

  // signed upper half of a dot product
  function automatic half_t half_hi(input dot_t a);
    return half_t'($signed(a[DOT_W-1:HALF_W]));
  endfunction

  // unsigned lower half of a dot product
  function automatic half_t half_lo(input dot_t a);
    return half_t'({1'b0, a[HALF_W-1:0]});
  endfunction

  // partial product j: high*high, high*low, low*high, low*low
  function automatic pp_t part_prod(input dot_t a, input dot_t b, input int j);
    half_t x, y;
    x = (j < 2) ? half_hi(a) : half_lo(a);
    y = (j[0] == 1'b0) ? half_hi(b) : half_lo(b);
    return pp_t'(x * y);
  endfunction

  // recombine the four partial products
  function automatic prod_t part_sum(input pp_t p [4]);
    return (prod_t'(p[0]) <<< (2 * HALF_W))
           + ((prod_t'(p[1]) + prod_t'(p[2])) <<< HALF_W)
           + prod_t'(p[3]);
  endfunction

  // valid chain
  logic v1_r, v2_r, vp_r, v3_r, v4_r, v6a_r, v6_r, v7_r, v8_r, out_valid_r;
  logic vd_r [DIV_LAT];

  logic en;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // input fields
  logic [VEC_BITS-1:0]  pa, pb, qa, qb;
  logic [RAD_BITS-1:0]  rad;
  logic [NVEC_BITS-1:0] nv;
  assign pa  = in_tdata[VEC_BITS-1:0];
  assign pb  = in_tdata[2*VEC_BITS-1:VEC_BITS];
  assign rad = in_tdata[2*VEC_BITS +: RAD_BITS];
  assign qa  = in_tdata[2*VEC_BITS+RAD_BITS +: VEC_BITS];
  assign qb  = in_tdata[3*VEC_BITS+RAD_BITS +: VEC_BITS];
  assign nv  = in_tdata[4*VEC_BITS+RAD_BITS +: NVEC_BITS];

  // stage 1: differences and normal times radius
  logic [KIND_W-1:0]        kind1_r;
  coord_t                   aa1_r [3];
  diff_t                    d1_1_r [3], d2_1_r [3], rr1_r [3], ap1_r [3];
  logic signed [NRP_W-1:0]  nrp1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      kind1_r <= in_tuser;
      for (int k = 0; k < 3; k++) begin
        aa1_r[k]  <= vec_comp(pa, k);
        d1_1_r[k] <= DIFF_W'(vec_comp(pb, k)) - DIFF_W'(vec_comp(pa, k));
        d2_1_r[k] <= DIFF_W'(vec_comp(qb, k)) - DIFF_W'(vec_comp(qa, k));
        rr1_r[k]  <= DIFF_W'(vec_comp(pa, k)) - DIFF_W'(vec_comp(qa, k));
        ap1_r[k]  <= DIFF_W'(vec_comp(qa, k)) - DIFF_W'(vec_comp(pa, k));
        nrp1_r[k] <= NRP_W'(nvec_comp(nv, k)) * $signed(NRP_W'(rad));
      end
    end
  end

  // stage 2: dot products and rounded normal offset
  logic [KIND_W-1:0] kind2_r;
  coord_t            aa2p_r [3];
  diff_t             d1_2_r [3];
  nr_t               nr2_r [3];
  dot_t              aa2_r, ee2_r, bb2_r, cc2_r, ff2_r, apd2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kind2_r <= kind1_r;
      for (int k = 0; k < 3; k++) begin
        aa2p_r[k] <= aa1_r[k];
        d1_2_r[k] <= d1_1_r[k];
        nr2_r[k]  <= NR_W'((nrp1_r[k] + $signed(NRP_W'(1) << (NORM_FRAC - 1)))
                     >>> NORM_FRAC);
      end
      aa2_r  <= dot3(d1_1_r[0], d1_1_r[1], d1_1_r[2], d1_1_r[0], d1_1_r[1], d1_1_r[2]);
      ee2_r  <= dot3(d2_1_r[0], d2_1_r[1], d2_1_r[2], d2_1_r[0], d2_1_r[1], d2_1_r[2]);
      bb2_r  <= dot3(d1_1_r[0], d1_1_r[1], d1_1_r[2], d2_1_r[0], d2_1_r[1], d2_1_r[2]);
      cc2_r  <= dot3(d1_1_r[0], d1_1_r[1], d1_1_r[2], rr1_r[0], rr1_r[1], rr1_r[2]);
      ff2_r  <= dot3(d2_1_r[0], d2_1_r[1], d2_1_r[2], rr1_r[0], rr1_r[1], rr1_r[2]);
      apd2_r <= dot3(ap1_r[0], ap1_r[1], ap1_r[2], d1_1_r[0], d1_1_r[1], d1_1_r[2]);
    end
  end

  // stage 3a: partial products of the determinant and numerator terms
  logic [KIND_W-1:0] kindp_r;
  coord_t            aapp_r [3];
  diff_t             d1_p_r [3];
  nr_t               nr_p_r [3];
  dot_t              aap_r, eep_r, bbp_r, ccp_r, ffp_r, apdp_r;
  pp_t               aaee_p_r [4], bbbb_p_r [4], bbff_p_r [4], ccee_p_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      kindp_r <= kind2_r;
      aapp_r  <= aa2p_r;
      d1_p_r  <= d1_2_r;
      nr_p_r  <= nr2_r;
      aap_r   <= aa2_r;
      eep_r   <= ee2_r;
      bbp_r   <= bb2_r;
      ccp_r   <= cc2_r;
      ffp_r   <= ff2_r;
      apdp_r  <= apd2_r;
      for (int j = 0; j < 4; j++) begin
        aaee_p_r[j] <= part_prod(aa2_r, ee2_r, j);
        bbbb_p_r[j] <= part_prod(bb2_r, bb2_r, j);
        bbff_p_r[j] <= part_prod(bb2_r, ff2_r, j);
        ccee_p_r[j] <= part_prod(cc2_r, ee2_r, j);
      end
    end
  end

  // stage 3b: determinant and numerator products
  logic [KIND_W-1:0] kind3_r;
  coord_t            aa3p_r [3];
  diff_t             d1_3_r [3];
  nr_t               nr3_r [3];
  dot_t              aa3_r, ee3_r, bb3_r, cc3_r, ff3_r, apd3_r;
  prod_t             aaee3_r, bbbb3_r, bbff3_r, ccee3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      kind3_r <= kindp_r;
      aa3p_r  <= aapp_r;
      d1_3_r  <= d1_p_r;
      nr3_r   <= nr_p_r;
      aa3_r   <= aap_r;
      ee3_r   <= eep_r;
      bb3_r   <= bbp_r;
      cc3_r   <= ccp_r;
      ff3_r   <= ffp_r;
      apd3_r  <= apdp_r;
      aaee3_r <= part_sum(aaee_p_r);
      bbbb3_r <= part_sum(bbbb_p_r);
      bbff3_r <= part_sum(bbff_p_r);
      ccee3_r <= part_sum(ccee_p_r);
    end
  end

  // stage 4: divider operand selection and case flags
  logic signed [DIV_W-1:0] den_c, num_c;
  logic                    eez_c, azero_c, capcap_c;
  side_t                   side_c, side4_r;
  logic signed [DIV_W-1:0] num1_4_r, den1_4_r, num2_4_r, num3_4_r, dena_4_r;

  always_comb begin
    den_c    = DIV_W'(aaee3_r) - DIV_W'(bbbb3_r);
    num_c    = DIV_W'(bbff3_r) - DIV_W'(ccee3_r);
    eez_c    = (ee3_r == '0);
    azero_c  = (aa3_r == '0);
    capcap_c = kind3_r[1];
    side_c.kind  = kind3_r;
    side_c.azero = azero_c;
    side_c.zs    = azero_c || (capcap_c && !eez_c && (den_c <= 0));
    side_c.corr  = capcap_c && !eez_c && !azero_c;
    side_c.bb    = bb3_r;
    side_c.ff    = ff3_r;
    side_c.ee    = ee3_r;
    for (int k = 0; k < 3; k++) begin
      side_c.apa[k*COORD_BITS +: COORD_BITS] = aa3p_r[k];
      side_c.d1[k*DIFF_W +: DIFF_W]          = d1_3_r[k];
      side_c.nr[k*NR_W +: NR_W]              = nr3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r  <= side_c;
      num1_4_r <= !capcap_c ? DIV_W'(apd3_r) : (eez_c ? -DIV_W'(cc3_r) : num_c);
      den1_4_r <= (!capcap_c || eez_c) ? DIV_W'(aa3_r) : den_c;
      num2_4_r <= -DIV_W'(cc3_r);
      num3_4_r <= DIV_W'(bb3_r) - DIV_W'(cc3_r);
      dena_4_r <= DIV_W'(aa3_r);
    end
  end

  // three dividers: main parameter, and the two fallbacks for the B clamp
  logic [Q_W-1:0] q1, q2, q3;

  ccp_div u_div_main (.clk(clk), .en(en), .num(num1_4_r), .den(den1_4_r), .quot(q1));
  ccp_div u_div_low  (.clk(clk), .en(en), .num(num2_4_r), .den(dena_4_r), .quot(q2));
  ccp_div u_div_high (.clk(clk), .en(en), .num(num3_4_r), .den(dena_4_r), .quot(q3));

  // side data delay matching the divider
  side_t sd_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= side4_r;
      for (int k = 1; k < DIV_LAT; k++) sd_r[k] <= sd_r[k-1];
    end
  end

  // stage 6a: partial products of bb times the first estimate
  side_t                    side5;
  logic [Q_W-1:0]           s1_c;
  logic signed [Q_W:0]      sq_c;
  side_t                    side6a_r;
  logic [Q_W-1:0]           s1_6a_r, q2_6a_r, q3_6a_r;
  logic signed [TP_W-1:0]   tph6a_r, tpl6a_r;

  assign side5 = sd_r[DIV_LAT-1];
  assign s1_c  = side5.zs ? '0 : q1;
  assign sq_c  = $signed({1'b0, s1_c});

  always_ff @(posedge clk) begin
    if (en) begin
      side6a_r <= side5;
      s1_6a_r  <= s1_c;
      q2_6a_r  <= q2;
      q3_6a_r  <= q3;
      tph6a_r  <= TP_W'(half_hi(dot_t'(side5.bb)) * sq_c);
      tpl6a_r  <= TP_W'(half_lo(dot_t'(side5.bb)) * sq_c);
    end
  end

  // stage 6b: parameter on B for the first estimate
  side_t                  side6_r;
  logic [Q_W-1:0]         s1_6_r, q2_6_r, q3_6_r;
  logic signed [TN_W-1:0] tnum6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side6a_r;
      s1_6_r  <= s1_6a_r;
      q2_6_r  <= q2_6a_r;
      q3_6_r  <= q3_6a_r;
      tnum6_r <= (TN_W'(tph6a_r) <<< HALF_W) + TN_W'(tpl6a_r)
                 + (TN_W'(dot_t'(side6a_r.ff)) <<< SEG_FRAC);
    end
  end

  // stage 7: final segment parameter on A
  logic signed [TN_W-1:0] eel_c;
  logic [Q_W-1:0]         s_c, s7_r;
  side_t                  side7_r;

  always_comb begin
    eel_c = TN_W'(dot_t'(side6_r.ee)) <<< SEG_FRAC;
    if (side6_r.azero) begin
      s_c = '0;
    end else if (!side6_r.corr) begin
      s_c = s1_6_r;
    end else if (tnum6_r < 0) begin
      s_c = q2_6_r;
    end else if (eel_c < tnum6_r) begin
      s_c = q3_6_r;
    end else begin
      s_c = s1_6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r    <= s_c;
      side7_r <= side6_r;
    end
  end

  // stage 8: segment direction times parameter
  logic signed [DPS_W-1:0] dps8_r [3];
  side_t                   side8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side8_r <= side7_r;
      for (int k = 0; k < 3; k++) begin
        dps8_r[k] <= DPS_W'(diff_t'(side7_r.d1[k*DIFF_W +: DIFF_W]))
                     * DPS_W'($signed({1'b0, s7_r}));
      end
    end
  end

  // stage 9: base point, normal offset, saturation
  logic [OUT_RAW_W-1:0] res_c;
  logic [OUT_RAW_W-1:0] res_r;

  always_comb begin
    logic signed [RND_W-1:0]  rnd;
    logic signed [BASE_W-1:0] base;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  hi_lim, lo_lim;
    hi_lim = SUM_W'((1 << (COORD_BITS - 1)) - 1);
    lo_lim = -hi_lim - SUM_W'(1);
    for (int k = 0; k < 3; k++) begin
      rnd  = RND_W'((dps8_r[k] + $signed(DPS_W'(1) << (SEG_FRAC - 1))) >>> SEG_FRAC);
      base = BASE_W'(coord_t'(side8_r.apa[k*COORD_BITS +: COORD_BITS]));
      if (side8_r.kind == KIND_SPHERE) begin
        sum = SUM_W'(base) + SUM_W'(nr_t'(side8_r.nr[k*NR_W +: NR_W]));
      end else begin
        base = base + BASE_W'(rnd);
        sum  = SUM_W'(base) - SUM_W'(nr_t'(side8_r.nr[k*NR_W +: NR_W]));
      end
      if (sum > hi_lim) sum = hi_lim;
      if (sum < lo_lim) sum = lo_lim;
      res_c[k*COORD_BITS +: COORD_BITS] = sum[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_c;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vp_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v6a_r       <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < DIV_LAT; k++) vd_r[k] <= 1'b0;
    end else if (en) begin
      v1_r    <= in_tvalid;
      v2_r    <= v1_r;
      vp_r    <= v2_r;
      v3_r    <= vp_r;
      v4_r    <= v3_r;
      vd_r[0] <= v4_r;
      for (int k = 1; k < DIV_LAT; k++) vd_r[k] <= vd_r[k-1];
      v6a_r       <= vd_r[DIV_LAT-1];
      v6_r        <= v6a_r;
      v7_r        <= v6_r;
      v8_r        <= v7_r;
      out_valid_r <= v8_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_RAW_W){1'b0}}, res_r};

endmodule
`default_nettype wire
